// ----- src/gcdg_pkg.sv -----
// Shared types and constants for the grid central-difference gradient block.
package gcdg_pkg;

  localparam int unsigned CoordW        = 9;   // holds any index up to 511
  localparam int unsigned CostW         = 32;
  localparam int unsigned InvW          = 24;
  localparam int unsigned DiffW         = CostW + 1;
  localparam int unsigned ProdW         = DiffW + InvW + 1;
  localparam int unsigned FracShift     = 16;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 24;
  localparam int unsigned DefMaxCellsX  = 64;
  localparam int unsigned DefMaxCellsY  = 64;
  localparam int unsigned DefMaxCellsZ  = 16;
  localparam int unsigned DefQueueDepth = 2;

  localparam logic [6:0]      SizeXReset  = 7'd64;
  localparam logic [6:0]      SizeYReset  = 7'd64;
  localparam logic [4:0]      SizeZReset  = 5'd16;
  localparam logic [InvW-1:0] InvResReset = 24'd65536;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRID_ENABLED,
    CFG_SIZE_X,
    CFG_SIZE_Y,
    CFG_SIZE_Z,
    CFG_INV_RESOLUTION
  } cfg_index_e;

  typedef struct packed {
    logic                   grid_enabled;
    logic [6:0]             size_x;
    logic [6:0]             size_y;
    logic [4:0]             size_z;
    logic [InvW-1:0]        inv_resolution;
  } cfg_t;

  typedef struct packed {
    logic                    mode;
    logic [5:0]              cell_x;
    logic [5:0]              cell_y;
    logic [3:0]              cell_z;
    logic signed [CostW-1:0] cost_value;
    logic                    cost_valid;
    logic                    cost_finite;
  } in_item_t;

  typedef struct packed {
    logic signed [CostW-1:0] grad_x;
    logic signed [CostW-1:0] grad_y;
    logic signed [CostW-1:0] grad_z;
    logic                    updated;
    logic                    index_error;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_QUERY,
    CMD_NO_UPDATE,
    CMD_INDEX_ERROR
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e               kind;
    logic [CoordW-1:0]       x;
    logic [CoordW-1:0]       y;
    logic [CoordW-1:0]       z;
    logic [CoordW-1:0]       xm;
    logic [CoordW-1:0]       xp;
    logic [CoordW-1:0]       ym;
    logic [CoordW-1:0]       yp;
    logic [CoordW-1:0]       zm;
    logic [CoordW-1:0]       zp;
    logic [1:0]              span_x;
    logic [1:0]              span_y;
    logic [1:0]              span_z;
    logic signed [CostW-1:0] cost;
    logic                    cost_valid;
    logic                    cost_finite;
  } cmd_t;

  typedef struct packed {
    logic                    finite;
    logic                    valid;
    logic signed [CostW-1:0] cost;
  } cell_word_t;

  typedef enum logic [2:0] {
    SLOT_CENTER,
    SLOT_XM,
    SLOT_XP,
    SLOT_YM,
    SLOT_YP,
    SLOT_ZM,
    SLOT_ZP
  } slot_e;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_ISSUE,
    B_DRAIN,
    B_DONE
  } back_state_e;

endpackage

// ----- src/gcdg_front.sv -----
// Front end: accepts input items, classifies them and works out neighbour indices.
module gcdg_front import gcdg_pkg::*; #(
  parameter int unsigned MaxX = DefMaxCellsX,
  parameter int unsigned MaxY = DefMaxCellsY,
  parameter int unsigned MaxZ = DefMaxCellsZ
) (
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  input  cfg_t     cfg_i,
  input  logic     clearing_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output cmd_t     q_data_o
);

  localparam logic [CoordW-1:0] MaxXC = CoordW'(MaxX);
  localparam logic [CoordW-1:0] MaxYC = CoordW'(MaxY);
  localparam logic [CoordW-1:0] MaxZC = CoordW'(MaxZ);

  function automatic logic [CoordW-1:0] eff_size(input logic [CoordW-1:0] s,
                                                 input logic [CoordW-1:0] m);
    logic [CoordW-1:0] r;
    if (s == '0) begin
      r = CoordW'(1);
    end else if (s > m) begin
      r = m;
    end else begin
      r = s;
    end
    return r;
  endfunction

  function automatic logic [CoordW-1:0] lo_nb(input logic [CoordW-1:0] c);
    return (c == '0) ? '0 : c - CoordW'(1);
  endfunction

  function automatic logic [CoordW-1:0] hi_nb(input logic [CoordW-1:0] c,
                                              input logic [CoordW-1:0] n);
    return (c + CoordW'(1) < n) ? c + CoordW'(1) : n - CoordW'(1);
  endfunction

  logic [CoordW-1:0] x, y, z;
  logic [CoordW-1:0] nx, ny, nz;
  logic              keep;

  assign x  = CoordW'(in_data_i.cell_x);
  assign y  = CoordW'(in_data_i.cell_y);
  assign z  = CoordW'(in_data_i.cell_z);
  assign nx = eff_size(CoordW'(cfg_i.size_x), MaxXC);
  assign ny = eff_size(CoordW'(cfg_i.size_y), MaxYC);
  assign nz = eff_size(CoordW'(cfg_i.size_z), MaxZC);

  assign in_ready_o = !q_full_i && !clearing_i;

  always_comb begin
    q_data_o             = '0;
    q_data_o.x           = x;
    q_data_o.y           = y;
    q_data_o.z           = z;
    q_data_o.xm          = lo_nb(x);
    q_data_o.xp          = hi_nb(x, nx);
    q_data_o.ym          = lo_nb(y);
    q_data_o.yp          = hi_nb(y, ny);
    q_data_o.zm          = lo_nb(z);
    q_data_o.zp          = hi_nb(z, nz);
    q_data_o.span_x      = 2'(q_data_o.xp - q_data_o.xm);
    q_data_o.span_y      = 2'(q_data_o.yp - q_data_o.ym);
    q_data_o.span_z      = 2'(q_data_o.zp - q_data_o.zm);
    q_data_o.cost        = in_data_i.cost_value;
    q_data_o.cost_valid  = in_data_i.cost_valid;
    q_data_o.cost_finite = in_data_i.cost_finite;
    keep                 = 1'b1;
    if (!in_data_i.mode) begin
      q_data_o.kind = CMD_LOAD;
      // loads beyond the physical grid are dropped
      keep = (x < MaxXC) && (y < MaxYC) && (z < MaxZC);
    end else if (!cfg_i.grid_enabled) begin
      q_data_o.kind = CMD_NO_UPDATE;
    end else if (x >= nx || y >= ny || z >= nz) begin
      q_data_o.kind = CMD_INDEX_ERROR;
    end else begin
      q_data_o.kind = CMD_QUERY;
    end
  end

  assign q_push_o = in_valid_i && in_ready_o && keep;

endmodule

// ----- src/gcdg_queue.sv -----
// Short command queue between the front end and the back end.
module gcdg_queue import gcdg_pkg::*; #(
  parameter int unsigned Depth = DefQueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = slots_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- src/gcdg_back.sv -----
// Back end: cell memory, clearing pass, neighbour read sequencer and gradient datapath.
module gcdg_back import gcdg_pkg::*; #(
  parameter int unsigned MaxX = DefMaxCellsX,
  parameter int unsigned MaxY = DefMaxCellsY,
  parameter int unsigned MaxZ = DefMaxCellsZ
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  output logic      clearing_o,
  input  logic      q_valid_i,
  input  cmd_t      q_data_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned XW       = (MaxX > 1) ? $clog2(MaxX) : 1;
  localparam int unsigned YW       = (MaxY > 1) ? $clog2(MaxY) : 1;
  localparam int unsigned ZW       = (MaxZ > 1) ? $clog2(MaxZ) : 1;
  localparam int unsigned AW       = XW + YW + ZW;
  localparam int unsigned MemDepth = 1 << AW;
  localparam logic [1:0]  DrainLast = 2'd2;

  function automatic logic [AW-1:0] cell_addr(input logic [CoordW-1:0] x,
                                              input logic [CoordW-1:0] y,
                                              input logic [CoordW-1:0] z);
    return {x[XW-1:0], y[YW-1:0], z[ZW-1:0]};
  endfunction

  function automatic slot_e next_slot(input slot_e s);
    slot_e r;
    unique case (s)
      SLOT_CENTER: r = SLOT_XM;
      SLOT_XM:     r = SLOT_XP;
      SLOT_XP:     r = SLOT_YM;
      SLOT_YM:     r = SLOT_YP;
      SLOT_YP:     r = SLOT_ZM;
      SLOT_ZM:     r = SLOT_ZP;
      default:     r = SLOT_CENTER;
    endcase
    return r;
  endfunction

  back_state_e state_q, state_d;
  cmd_t        cur_q;
  slot_e       slot_q;
  logic [1:0]  drain_q;
  logic [AW-1:0] clr_addr_q;

  cell_word_t  mem [MemDepth];
  cell_word_t  rd_q;
  logic        mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  cell_word_t  mem_wdata;

  logic        out_take;
  logic        out_valid_q;
  out_item_t   out_q;

  // datapath stages
  logic                    rd_vld_q;
  slot_e                   rd_slot_q;
  logic                    center_ok_q;
  logic signed [CostW-1:0] m_cost_q;
  logic                    m_ok_q;
  logic                    d_vld_q, d_ok_q, d_sh_q;
  slot_e                   d_slot_q;
  logic signed [DiffW-1:0] diff_q;
  logic                    p_vld_q, p_ok_q, p_sh_q;
  slot_e                   p_slot_q;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic signed [InvW:0]    inv_s;
  logic signed [ProdW-1:0] half, rounded, shifted;
  logic [CostW-1:0]        sat;
  logic [CostW-1:0]        g_val;
  logic signed [CostW-1:0] gx_q, gy_q, gz_q;
  logic                    p_ok_rd, plus_slot, minus_slot;
  logic [1:0]              span_sel;
  logic                    query_ok;

  assign clearing_o = (state_q == B_CLEAR);
  assign out_take   = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_CLEAR: begin
        if (clr_addr_q == '1) state_d = B_IDLE;
      end
      B_IDLE: begin
        if (q_valid_i) begin
          unique case (q_data_i.kind)
            CMD_LOAD:  state_d = B_IDLE;
            CMD_QUERY: state_d = B_ISSUE;
            default:   state_d = B_DONE;
          endcase
        end
      end
      B_ISSUE: begin
        if (slot_q == SLOT_ZP) state_d = B_DRAIN;
      end
      B_DRAIN: begin
        if (drain_q == DrainLast) state_d = B_DONE;
      end
      B_DONE: begin
        if (out_take) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop_o   = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = cell_addr(q_data_i.x, q_data_i.y, q_data_i.z);
    mem_wdata = '{finite: q_data_i.cost_finite, valid: q_data_i.cost_valid,
                  cost: q_data_i.cost};
    unique case (state_q)
      B_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr_q;
        mem_wdata = '0;
      end
      B_IDLE: begin
        q_pop_o = q_valid_i;
        mem_we  = q_valid_i && (q_data_i.kind == CMD_LOAD);
      end
      B_ISSUE: begin
        mem_re = 1'b1;
        unique case (slot_q)
          SLOT_CENTER: mem_addr = cell_addr(cur_q.x,  cur_q.y,  cur_q.z);
          SLOT_XM:     mem_addr = cell_addr(cur_q.xm, cur_q.y,  cur_q.z);
          SLOT_XP:     mem_addr = cell_addr(cur_q.xp, cur_q.y,  cur_q.z);
          SLOT_YM:     mem_addr = cell_addr(cur_q.x,  cur_q.ym, cur_q.z);
          SLOT_YP:     mem_addr = cell_addr(cur_q.x,  cur_q.yp, cur_q.z);
          SLOT_ZM:     mem_addr = cell_addr(cur_q.x,  cur_q.y,  cur_q.zm);
          default:     mem_addr = cell_addr(cur_q.x,  cur_q.y,  cur_q.zp);
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      slot_q      <= SLOT_CENTER;
      drain_q     <= '0;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      d_vld_q     <= 1'b0;
      p_vld_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= mem_re;
      d_vld_q  <= rd_vld_q && plus_slot;
      p_vld_q  <= d_vld_q;
      if (state_q == B_CLEAR) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      if (state_q == B_IDLE) begin
        slot_q <= SLOT_CENTER;
      end else if (state_q == B_ISSUE) begin
        slot_q  <= next_slot(slot_q);
        drain_q <= '0;
      end else if (state_q == B_DRAIN) begin
        drain_q <= drain_q + 2'd1;
      end
      if (state_q == B_DONE && out_take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_data_i;
    end
  end

  // single-port cell memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      rd_q <= mem[mem_addr];
    end
  end

  // read data stage: pair minus and plus neighbours into a difference
  always_comb begin
    minus_slot = (rd_slot_q == SLOT_XM) || (rd_slot_q == SLOT_YM) ||
                 (rd_slot_q == SLOT_ZM);
    plus_slot  = (rd_slot_q == SLOT_XP) || (rd_slot_q == SLOT_YP) ||
                 (rd_slot_q == SLOT_ZP);
    p_ok_rd    = rd_q.valid && rd_q.finite;
    unique case (rd_slot_q)
      SLOT_XP: span_sel = cur_q.span_x;
      SLOT_YP: span_sel = cur_q.span_y;
      default: span_sel = cur_q.span_z;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd_slot_q <= slot_q;
    if (rd_vld_q) begin
      if (rd_slot_q == SLOT_CENTER) begin
        center_ok_q <= rd_q.valid;
      end
      if (minus_slot) begin
        m_cost_q <= rd_q.cost;
        m_ok_q   <= rd_q.valid && rd_q.finite;
      end
      if (plus_slot) begin
        diff_q   <= DiffW'(rd_q.cost) - DiffW'(m_cost_q);
        d_ok_q   <= m_ok_q && p_ok_rd && (span_sel != 2'd0);
        d_sh_q   <= (span_sel == 2'd2);
        d_slot_q <= rd_slot_q;
      end
    end
  end

  // multiply stage
  assign inv_s  = $signed({1'b0, cfg_i.inv_resolution});
  assign prod_d = diff_q * inv_s;

  always_ff @(posedge clk_i) begin
    if (d_vld_q) begin
      prod_q   <= prod_d;
      p_ok_q   <= d_ok_q;
      p_sh_q   <= d_sh_q;
      p_slot_q <= d_slot_q;
    end
  end

  // round half up, shift, saturate
  always_comb begin
    half    = p_sh_q ? (ProdW'(1) <<< FracShift) : (ProdW'(1) <<< (FracShift - 1));
    rounded = prod_q + half;
    shifted = p_sh_q ? (rounded >>> (FracShift + 1)) : (rounded >>> FracShift);
    if ((&shifted[ProdW-1:CostW-1]) || !(|shifted[ProdW-1:CostW-1])) begin
      sat = shifted[CostW-1:0];
    end else if (shifted[ProdW-1]) begin
      sat = {1'b1, {(CostW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(CostW-1){1'b1}}};
    end
    g_val = p_ok_q ? sat : '0;
  end

  always_ff @(posedge clk_i) begin
    if (p_vld_q) begin
      unique case (p_slot_q)
        SLOT_XP: gx_q <= g_val;
        SLOT_YP: gy_q <= g_val;
        default: gz_q <= g_val;
      endcase
    end
  end

  // output register
  assign query_ok = (cur_q.kind == CMD_QUERY) && center_ok_q;

  always_ff @(posedge clk_i) begin
    if (state_q == B_DONE && out_take) begin
      out_q.grad_x      <= query_ok ? gx_q : '0;
      out_q.grad_y      <= query_ok ? gy_q : '0;
      out_q.grad_z      <= query_ok ? gz_q : '0;
      out_q.updated     <= query_ok;
      out_q.index_error <= (cur_q.kind == CMD_INDEX_ERROR);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- src/grid_central_difference_gradient.sv -----
// Top level of the grid central-difference gradient block: config registers and wiring.
//
//   channel  | signals                              | transfer when
//   ---------+--------------------------------------+---------------------------
//   input    | in_valid_i, in_ready_o, in_data_i    | in_valid_i & in_ready_o
//   output   | out_valid_o, out_ready_i, out_data_o | out_valid_o & out_ready_i
//   config   | cfg_we_i, cfg_index_i, cfg_data_i    | cfg_we_i
//
// In the back end a query is popped, then seven reads (center plus six neighbours) go over
// the single cell memory port, the datapath drains and the output register is loaded.
// A load is written to the cell memory as it is popped. The command queue lets the front
// keep accepting while it has room. After reset a clearing pass clears the marks of all
// 2**(address bits) cells (65536 at the default sizes); no item is accepted meanwhile, config writes are.
// A stalled output holds its register; the back end waits at completion only.
module grid_central_difference_gradient import gcdg_pkg::*; #(
  parameter int unsigned MAX_CELLS_X = DefMaxCellsX,
  parameter int unsigned MAX_CELLS_Y = DefMaxCellsY,
  parameter int unsigned MAX_CELLS_Z = DefMaxCellsZ,
  parameter int unsigned QUEUE_DEPTH = DefQueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t cfg_q;
  logic clearing;
  logic q_push, q_full, q_pop, q_valid;
  cmd_t q_in, q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_enabled   <= 1'b0;
      cfg_q.size_x         <= SizeXReset;
      cfg_q.size_y         <= SizeYReset;
      cfg_q.size_z         <= SizeZReset;
      cfg_q.inv_resolution <= InvResReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_GRID_ENABLED:   cfg_q.grid_enabled   <= cfg_data_i[0];
        CFG_SIZE_X:         cfg_q.size_x         <= cfg_data_i[6:0];
        CFG_SIZE_Y:         cfg_q.size_y         <= cfg_data_i[6:0];
        CFG_SIZE_Z:         cfg_q.size_z         <= cfg_data_i[4:0];
        CFG_INV_RESOLUTION: cfg_q.inv_resolution <= cfg_data_i[InvW-1:0];
        default: begin
        end
      endcase
    end
  end

  gcdg_front #(
    .MaxX (MAX_CELLS_X),
    .MaxY (MAX_CELLS_Y),
    .MaxZ (MAX_CELLS_Z)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .clearing_i (clearing),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_in)
  );

  gcdg_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_out)
  );

  gcdg_back #(
    .MaxX (MAX_CELLS_X),
    .MaxY (MAX_CELLS_Y),
    .MaxZ (MAX_CELLS_Z)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .clearing_o  (clearing),
    .q_valid_i   (q_valid),
    .q_data_i    (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- bench/grid_central_difference_gradient_check.sv -----
// Checker for the grid gradient block: shadows config and cell store, predicts and compares.
`timescale 1ns / 1ps
module grid_central_difference_gradient_check import gcdg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  in_item_t            in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  out_item_t           out_data_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  pending_o,
  output int                  fail_count_o
);

  localparam int unsigned CellCount  = DefMaxCellsX * DefMaxCellsY * DefMaxCellsZ;
  localparam int unsigned MaxReports = 10;
  localparam int          ExpDepth   = 16;  // far above what the block can hold in flight
  localparam longint      GradMax    = 64'sd2147483647;
  localparam longint      GradMin    = -64'sd2147483648;

  cfg_t        setup;
  cell_word_t  cell_mem [CellCount];
  out_item_t   expected_gradients [ExpDepth];
  int          exp_head   = 0;
  int          exp_tail   = 0;
  int          mismatches = 0;
  int          waiting    = 0;

  assign pending_o    = waiting;
  assign fail_count_o = mismatches;

  function automatic logic [15:0] cell_address(int unsigned x, int unsigned y, int unsigned z);
    logic [5:0] xa;
    logic [5:0] ya;
    logic [3:0] za;
    xa = x[5:0];
    ya = y[5:0];
    za = z[3:0];
    return {xa, ya, za};
  endfunction

  function automatic int unsigned used_size(int unsigned s, int unsigned limit);
    if (s == 0) return 1;
    return (s > limit) ? limit : s;
  endfunction

  // Difference of the two neighbours scaled by the inverse resolution; span 2 halves it.
  function automatic logic signed [31:0] axis_slope(logic [15:0] lo_addr, logic [15:0] hi_addr,
                                                    int unsigned span);
    cell_word_t  lo;
    cell_word_t  hi;
    longint      diff;
    longint      prod;
    longint      g;
    int unsigned sh;
    lo = cell_mem[lo_addr];
    hi = cell_mem[hi_addr];
    if (span == 0) return '0;
    if (!(lo.valid && lo.finite && hi.valid && hi.finite)) return '0;
    diff = longint'(hi.cost) - longint'(lo.cost);
    prod = diff * longint'({40'd0, setup.inv_resolution});
    sh   = (span == 2) ? FracShift + 1 : FracShift;
    g    = (prod + (longint'(1) <<< (sh - 1))) >>> sh;
    if (g > GradMax) g = GradMax;
    if (g < GradMin) g = GradMin;
    return g[31:0];
  endfunction

  function automatic out_item_t predict_gradients(in_item_t item);
    out_item_t   res;
    int unsigned nx, ny, nz, x, y, z;
    int unsigned xm, xp, ym, yp, zm, zp;
    res = '0;
    if (!setup.grid_enabled) return res;
    nx = used_size(setup.size_x, DefMaxCellsX);
    ny = used_size(setup.size_y, DefMaxCellsY);
    nz = used_size(setup.size_z, DefMaxCellsZ);
    x  = item.cell_x;
    y  = item.cell_y;
    z  = item.cell_z;
    if (x >= nx || y >= ny || z >= nz) begin
      res.index_error = 1'b1;
      return res;
    end
    if (!cell_mem[cell_address(x, y, z)].valid) return res;
    // neighbours clamp to the grid, so edge cells get a one-sided difference
    xm = (x > 0) ? x - 1 : 0;
    xp = (x + 1 < nx) ? x + 1 : nx - 1;
    ym = (y > 0) ? y - 1 : 0;
    yp = (y + 1 < ny) ? y + 1 : ny - 1;
    zm = (z > 0) ? z - 1 : 0;
    zp = (z + 1 < nz) ? z + 1 : nz - 1;
    res.grad_x  = axis_slope(cell_address(xm, y, z), cell_address(xp, y, z), xp - xm);
    res.grad_y  = axis_slope(cell_address(x, ym, z), cell_address(x, yp, z), yp - ym);
    res.grad_z  = axis_slope(cell_address(x, y, zm), cell_address(x, y, zp), zp - zm);
    res.updated = 1'b1;
    return res;
  endfunction

  task automatic flag_mismatch(string what, out_item_t want, out_item_t got);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("%0t: %s: expected gx=%0d gy=%0d gz=%0d upd=%0b err=%0b", $realtime, what,
               want.grad_x, want.grad_y, want.grad_z, want.updated, want.index_error);
      $display("%0t: %s: actual   gx=%0d gy=%0d gz=%0d upd=%0b err=%0b", $realtime, what,
               got.grad_x, got.grad_y, got.grad_z, got.updated, got.index_error);
    end
  endtask

  task automatic compare_result(out_item_t got);
    out_item_t want;
    if (exp_tail == exp_head) begin
      flag_mismatch("result with nothing outstanding", '0, got);
    end else begin
      want = expected_gradients[exp_head % ExpDepth];
      exp_head++;
      if (got.grad_x !== want.grad_x || got.grad_y !== want.grad_y ||
          got.grad_z !== want.grad_z || got.updated !== want.updated ||
          got.index_error !== want.index_error)
        flag_mismatch("gradient mismatch", want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup.grid_enabled   = 1'b0;
      setup.size_x         = SizeXReset;
      setup.size_y         = SizeYReset;
      setup.size_z         = SizeZReset;
      setup.inv_resolution = InvResReset;
      foreach (cell_mem[i]) cell_mem[i] = '0;
      exp_head = 0;
      exp_tail = 0;
      waiting  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_GRID_ENABLED:   setup.grid_enabled   = cfg_data_i[0];
          CFG_SIZE_X:         setup.size_x         = cfg_data_i[6:0];
          CFG_SIZE_Y:         setup.size_y         = cfg_data_i[6:0];
          CFG_SIZE_Z:         setup.size_z         = cfg_data_i[4:0];
          CFG_INV_RESOLUTION: setup.inv_resolution = cfg_data_i[InvW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) compare_result(out_data_i);
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.mode == 1'(CMD_LOAD)) begin
          cell_mem[cell_address(in_data_i.cell_x, in_data_i.cell_y, in_data_i.cell_z)] =
            '{finite: in_data_i.cost_finite, valid: in_data_i.cost_valid,
              cost: in_data_i.cost_value};
        end else begin
          expected_gradients[exp_tail % ExpDepth] = predict_gradients(in_data_i);
          exp_tail++;
        end
      end
      waiting = exp_tail - exp_head;
    end
  end

endmodule

// ----- bench/grid_central_difference_gradient_test.sv -----
// Testbench top for the grid gradient block: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module grid_central_difference_gradient_test;
  import gcdg_pkg::*;

  localparam int unsigned Phases        = 12;
  localparam int unsigned ItemsPerPhase = 145;
  localparam int unsigned MaxGap        = 19;
  localparam int unsigned BackendSlack  = 40;
  localparam int unsigned LastX         = DefMaxCellsX - 1;
  localparam int unsigned LastY         = DefMaxCellsY - 1;
  localparam int unsigned LastZ         = DefMaxCellsZ - 1;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int                  pending_count;
  int                  fail_count;
  bit                  quiet;
  int unsigned         used_x, used_y, used_z;
  int unsigned         base_x, base_y, base_z;  // corner of the box most cells come from

  grid_central_difference_gradient DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  grid_central_difference_gradient_check checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending_count),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #24_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: random stall before each transfer, none while quiet.
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, MaxGap);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      @(negedge clk_i);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(in_item_t item);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  task automatic load_cell(int unsigned x, int unsigned y, int unsigned z,
                           logic signed [31:0] cost, logic valid, logic finite);
    in_item_t item;
    item.mode        = 1'(CMD_LOAD);
    item.cell_x      = x[5:0];
    item.cell_y      = y[5:0];
    item.cell_z      = z[3:0];
    item.cost_value  = cost;
    item.cost_valid  = valid;
    item.cost_finite = finite;
    send_item(item);
  endtask

  // Cost and marks mean nothing to a query; fill them with noise.
  task automatic query_cell(int unsigned x, int unsigned y, int unsigned z);
    in_item_t item;
    item.mode        = 1'(CMD_QUERY);
    item.cell_x      = x[5:0];
    item.cell_y      = y[5:0];
    item.cell_z      = z[3:0];
    item.cost_value  = $urandom();
    item.cost_valid  = 1'($urandom_range(0, 1));
    item.cost_finite = 1'($urandom_range(0, 1));
    send_item(item);
  endtask

  // Stop sending, wait until every query has come back, then let loads still in flight finish.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending_count != 0);
    repeat (BackendSlack) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [CfgDataW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_setup(logic en, logic [6:0] sx, logic [6:0] sy, logic [4:0] sz,
                             logic [InvW-1:0] inv);
    drain_results();
    write_reg(CFG_GRID_ENABLED, CfgDataW'(en));
    write_reg(CFG_SIZE_X, CfgDataW'(sx));
    write_reg(CFG_SIZE_Y, CfgDataW'(sy));
    write_reg(CFG_SIZE_Z, CfgDataW'(sz));
    write_reg(CFG_INV_RESOLUTION, CfgDataW'(inv));
    used_x = (sx == 0) ? 1 : (sx > DefMaxCellsX) ? DefMaxCellsX : sx;
    used_y = (sy == 0) ? 1 : (sy > DefMaxCellsY) ? DefMaxCellsY : sy;
    used_z = (sz == 0) ? 1 : (sz > DefMaxCellsZ) ? DefMaxCellsZ : sz;
  endtask

  task automatic random_setup();
    logic            en;
    logic [6:0]      sx, sy;
    logic [4:0]      sz;
    logic [InvW-1:0] inv;
    en = ($urandom_range(0, 9) != 0);
    case ($urandom_range(0, 5))
      0:       sx = 7'd0;
      1:       sx = 7'd1;
      2:       sx = 7'd64;
      3:       sx = 7'($urandom_range(65, 127));
      default: sx = 7'($urandom_range(2, 8));
    endcase
    case ($urandom_range(0, 5))
      0:       sy = 7'd0;
      1:       sy = 7'd1;
      2:       sy = 7'd64;
      3:       sy = 7'($urandom_range(65, 127));
      default: sy = 7'($urandom_range(2, 8));
    endcase
    case ($urandom_range(0, 5))
      0:       sz = 5'd0;
      1:       sz = 5'd1;
      2:       sz = 5'd16;
      3:       sz = 5'($urandom_range(17, 31));
      default: sz = 5'($urandom_range(2, 4));
    endcase
    case ($urandom_range(0, 5))
      0:       inv = '0;
      1:       inv = '1;
      2:       inv = 24'd65536;
      3:       inv = InvW'($urandom_range(1, 255));
      default: inv = InvW'($urandom());
    endcase
    apply_setup(en, sx, sy, sz, inv);
    base_x = $urandom_range(0, used_x - 1);
    base_y = $urandom_range(0, used_y - 1);
    base_z = $urandom_range(0, used_z - 1);
  endtask

  // Mostly cells in a small box so queries find loaded neighbours; some anywhere.
  task automatic random_item();
    int unsigned        x, y, z;
    logic signed [31:0] cost;
    if ($urandom_range(0, 19) < 17) begin
      x = base_x + $urandom_range(0, 3);
      y = base_y + $urandom_range(0, 3);
      z = base_z + $urandom_range(0, 3);
      if (x > LastX) x = LastX;
      if (y > LastY) y = LastY;
      if (z > LastZ) z = LastZ;
    end else begin
      x = $urandom_range(0, LastX);
      y = $urandom_range(0, LastY);
      z = $urandom_range(0, LastZ);
    end
    case ($urandom_range(0, 9))
      0:       cost = 32'sh7FFF_FFFF;
      1:       cost = 32'sh8000_0000;
      2, 3, 4: cost = $urandom();
      default: cost = $urandom_range(0, 65535) - 32768;
    endcase
    if ($urandom_range(0, 19) < 11)
      load_cell(x, y, z, cost, $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
    else
      query_cell(x, y, z);
  endtask

  initial begin
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_GRID_ENABLED;
    cfg_data  = '0;
    quiet     = 1'b0;
    rst_ni    = 1'b0;
    used_x    = DefMaxCellsX;
    used_y    = DefMaxCellsY;
    used_z    = DefMaxCellsZ;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // grid still disabled from reset
    query_cell(1, 1, 1);
    // cluster around (1,1,1) plus the far corner
    load_cell(1, 1, 1, 32'sd4096, 1'b1, 1'b1);
    load_cell(0, 1, 1, 32'sh8000_0000, 1'b1, 1'b1);
    load_cell(2, 1, 1, 32'sh7FFF_FFFF, 1'b1, 1'b1);
    load_cell(1, 0, 1, -32'sd4096, 1'b1, 1'b1);
    load_cell(1, 2, 1, 32'sd12345, 1'b1, 1'b0);   // valid but not finite
    load_cell(1, 1, 0, 32'sd100, 1'b1, 1'b1);
    load_cell(1, 1, 2, -32'sd100, 1'b1, 1'b1);
    load_cell(5, 5, 5, 32'sd777, 1'b0, 1'b1);      // never valid
    load_cell(LastX, LastY, LastZ, 32'sh7FFF_FFFF, 1'b1, 1'b1);
    load_cell(LastX - 1, LastY, LastZ, 32'sh8000_0000, 1'b1, 1'b1);
    load_cell(LastX, LastY - 1, LastZ, 32'sd1, 1'b0, 1'b0);

    // full grid, largest scale: saturation, one-sided edges, invalid cells
    apply_setup(1'b1, 7'd64, 7'd64, 5'd16, '1);
    query_cell(1, 1, 1);
    query_cell(0, 1, 1);
    query_cell(LastX, LastY, LastZ);
    query_cell(5, 5, 5);
    query_cell(2, 1, 1);

    // size zero and sizes past the maximum, smallest nonzero scale
    apply_setup(1'b1, 7'd0, 7'd127, 5'd31, 24'd1);
    query_cell(1, 1, 1);
    query_cell(0, 1, 1);

    // 3x3x3 grid: interior cell halves, z out of range
    apply_setup(1'b1, 7'd3, 7'd3, 5'd3, 24'd65536);
    query_cell(1, 1, 1);
    query_cell(1, 1, 3);

    // zero scale
    apply_setup(1'b1, 7'd3, 7'd3, 5'd3, '0);
    query_cell(1, 1, 1);

    for (int unsigned phase = 0; phase < Phases; phase++) begin
      quiet = 1'b0;
      random_setup();
      quiet = ($urandom_range(0, 3) == 0);
      for (int unsigned n = 0; n < ItemsPerPhase; n++) begin
        if (phase == Phases / 2 && n == ItemsPerPhase / 2) drain_results();
        random_item();
      end
    end

    drain_results();
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- grid_central_difference_gradient.f -----
src/gcdg_pkg.sv
src/gcdg_front.sv
src/gcdg_queue.sv
src/gcdg_back.sv
src/grid_central_difference_gradient.sv
bench/grid_central_difference_gradient_check.sv
bench/grid_central_difference_gradient_test.sv
